// File: rtl/oamt_pkg.sv
// Package: shared constants and types for the open-addressing memo table.
`default_nettype none
package oamt_pkg;
    localparam int SLOTS_DEF       = 8192;
    localparam int HANDLE_BITS_DEF = 48;
    localparam int CNT_W           = 14;
    localparam int KEY_W           = 64;
    localparam int POS_W           = 3;
    localparam int STAT_W          = 3;

    // Register byte addresses on the APB port.
    localparam logic [1:0] REG_ENTRY_LIMIT = 2'd0;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_INVAL  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [2:0] RS_HIT      = 3'd0;
    localparam logic [2:0] RS_MISS     = 3'd1;
    localparam logic [2:0] RS_INSERTED = 3'd2;
    localparam logic [2:0] RS_PRESENT  = 3'd3;
    localparam logic [2:0] RS_REFUSED  = 3'd4;
    localparam logic [2:0] RS_INVAL    = 3'd5;
    localparam logic [2:0] RS_NOTFOUND = 3'd6;
    localparam logic [2:0] RS_CLEARED  = 3'd7;

    // Status-memory control from the probe engine.
    typedef struct packed {
        logic clr_start;
        logic wr_en;
    } stat_ctl_t;
endpackage
`default_nettype wire

// File: rtl/oamt_status_mem.sv
// Slot status memory with a clearing pass.
`default_nettype none
module oamt_status_mem #(
    parameter int SLOTS = oamt_pkg::SLOTS_DEF,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire oamt_pkg::stat_ctl_t ctl,
    input  wire  [AW-1:0]            rd_addr,
    input  wire  [AW-1:0]            wr_addr,
    input  wire  [1:0]               wr_data,
    output logic [1:0]               rd_data,
    output logic                     busy
);
    logic [1:0]    mem [SLOTS];
    logic [AW-1:0] clr_reg;
    logic          busy_reg;

    // Clear sweep: one entry per cycle, after reset and on clear-all.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (ctl.clr_start) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + AW'(1);
            if (clr_reg == AW'(SLOTS - 1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) mem[clr_reg] <= oamt_pkg::ST_EMPTY;
        else if (ctl.wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

// File: rtl/oamt_data_mem.sv
// Slot key and value memory, one slot per row.
`default_nettype none
module oamt_data_mem #(
    parameter int SLOTS = oamt_pkg::SLOTS_DEF,
    parameter int DW = 131,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire           aclk,
    input  wire           wr_en,
    input  wire  [AW-1:0] wr_addr,
    input  wire  [DW-1:0] wr_data,
    input  wire  [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: rtl/open_addressing_memo_table_top.sv
// Top level: probe sequencer, configuration port and result register.
//
// Open-addressing hash table of SLOTS slots with linear probing. Each item
// visits slots one at a time: each probe issues the read at the synchronous
// status and key memories, then compares. A finished result waits in the
// output register while the next item is probed; only a second result
// behind a stalled one holds the sequencer. After reset and after each
// clear-all the status memory is swept empty, one slot per cycle, while no
// item is taken.
// The register entry_limit lies at address 0 of the APB port.
`default_nettype none
module open_addressing_memo_table_top #(
    parameter int SLOTS       = oamt_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = oamt_pkg::HANDLE_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: key_a[63:0], key_b[127:64], value_id[175:128], operand_pos[178:176]
    input  wire  [183:0] s_tdata,
    // tuser: op
    input  wire  [1:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: found_value[47:0], found_pos[50:48], live[64:51], dead[78:65]
    output logic [79:0]  m_tdata,
    // tuser: status
    output logic [2:0]   m_tuser,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [1:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = oamt_pkg::CNT_W;
    localparam int KW = oamt_pkg::KEY_W;
    localparam int PW = oamt_pkg::POS_W;
    localparam int DW = 2 * KW + HANDLE_BITS + PW;
    localparam int LOAD_MAX = (SLOTS * 3) / 4;

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_CHECK, S_DONE, S_OUT} state_t;

    state_t               state_reg;
    logic [1:0]           op_reg;
    logic [KW-1:0]        ka_reg, kb_reg;
    logic [HANDLE_BITS-1:0] hd_reg;
    logic [PW-1:0]        pos_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW:0]          n_reg;
    logic                 tomb_v_reg, empty_v_reg;
    logic [AW-1:0]        tomb_reg, empty_reg;
    logic [CW-1:0]        live_reg, dead_reg, limit_reg;
    logic                 ov_reg;
    logic [2:0]           rs_reg;
    logic [HANDLE_BITS-1:0] fv_reg;
    logic [PW-1:0]        fp_reg;
    logic                 sw_reg;
    logic [AW-1:0]        wa_reg;
    logic [1:0]           wd_reg;
    logic                 dw_reg;

    oamt_pkg::stat_ctl_t  sctl;
    logic [1:0]           st_rd;
    logic                 busy;
    logic [DW-1:0]        d_rd;
    logic                 clr_go;

    wire [KW-1:0] s_ka = s_tdata[63:0];
    wire [KW-1:0] s_kb = s_tdata[127:64];
    wire [HANDLE_BITS-1:0] s_hd = s_tdata[128 +: HANDLE_BITS];
    wire [PW-1:0] s_pos = s_tdata[178:176];
    wire [KW-1:0] s_fold = s_ka ^ (s_ka >> 32);

    assign sctl.clr_start = clr_go;
    assign sctl.wr_en     = sw_reg;

    oamt_status_mem #(.SLOTS(SLOTS)) u_stat (
        .aclk(aclk), .aresetn(aresetn), .ctl(sctl), .rd_addr(idx_reg),
        .wr_addr(wa_reg), .wr_data(wd_reg), .rd_data(st_rd), .busy(busy));

    oamt_data_mem #(.SLOTS(SLOTS), .DW(DW)) u_data (
        .aclk(aclk), .wr_en(dw_reg), .wr_addr(wa_reg),
        .wr_data({pos_reg, hd_reg, kb_reg, ka_reg}),
        .rd_addr(idx_reg), .rd_data(d_rd));

    wire key_eq = d_rd[KW-1:0] == ka_reg && d_rd[2*KW-1:KW] == kb_reg;
    wire [HANDLE_BITS-1:0] d_hd = d_rd[2*KW +: HANDLE_BITS];
    wire [PW-1:0] d_pos = d_rd[2*KW+HANDLE_BITS +: PW];
    wire last_probe = n_reg == (AW+1)'(SLOTS - 1);
    wire [CW:0] used1 = {1'b0, live_reg} + {1'b0, dead_reg} + (CW+1)'(1);

    assign clr_go   = state_reg == S_DONE && op_reg == oamt_pkg::OP_CLEAR;
    assign s_tready = state_reg == S_IDLE && !busy;
    assign pready   = 1'b1;
    assign prdata   = {{(32-CW){1'b0}}, limit_reg};

    // Configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= CW'(8192);
        else if (psel && penable && pwrite && paddr == oamt_pkg::REG_ENTRY_LIMIT)
            limit_reg <= pwdata[CW-1:0];
    end

    // Probe sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            dead_reg  <= '0;
            ov_reg    <= 1'b0;
            sw_reg    <= 1'b0;
            dw_reg    <= 1'b0;
        end else begin
            sw_reg <= 1'b0;
            dw_reg <= 1'b0;
            // Output register drains; S_OUT refills it itself.
            if (ov_reg && m_tready && state_reg != S_OUT) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    op_reg      <= s_tuser;
                    ka_reg      <= s_ka;
                    kb_reg      <= s_kb;
                    hd_reg      <= s_hd;
                    pos_reg     <= s_pos;
                    idx_reg     <= s_fold[AW-1:0];
                    n_reg       <= '0;
                    tomb_v_reg  <= 1'b0;
                    empty_v_reg <= 1'b0;
                    fv_reg      <= '0;
                    fp_reg      <= '0;
                    state_reg   <= (s_tuser == oamt_pkg::OP_CLEAR) ? S_DONE : S_ISSUE;
                end
                S_ISSUE: state_reg <= S_CHECK;
                S_CHECK: begin
                    state_reg <= S_ISSUE;
                    if (st_rd == oamt_pkg::ST_EMPTY) begin
                        empty_v_reg <= 1'b1;
                        empty_reg   <= idx_reg;
                        rs_reg      <= op_reg == oamt_pkg::OP_LOOKUP ? oamt_pkg::RS_MISS :
                                       op_reg == oamt_pkg::OP_INVAL ? oamt_pkg::RS_NOTFOUND :
                                       oamt_pkg::RS_REFUSED;
                        state_reg   <= S_DONE;
                    end else if (st_rd == oamt_pkg::ST_LIVE && key_eq &&
                                 (op_reg != oamt_pkg::OP_INVAL || d_hd == hd_reg)) begin
                        state_reg <= S_DONE;
                        case (op_reg)
                            oamt_pkg::OP_LOOKUP: begin
                                rs_reg <= oamt_pkg::RS_HIT;
                                fv_reg <= d_hd;
                                fp_reg <= d_pos;
                            end
                            oamt_pkg::OP_INSERT: rs_reg <= oamt_pkg::RS_PRESENT;
                            default: rs_reg <= oamt_pkg::RS_INVAL;
                        endcase
                    end else begin
                        if (st_rd == oamt_pkg::ST_TOMB && !tomb_v_reg) begin
                            tomb_v_reg <= 1'b1;
                            tomb_reg   <= idx_reg;
                        end
                        idx_reg <= idx_reg + AW'(1);
                        n_reg   <= n_reg + (AW+1)'(1);
                        if (last_probe) begin
                            rs_reg    <= op_reg == oamt_pkg::OP_LOOKUP ? oamt_pkg::RS_MISS :
                                         op_reg == oamt_pkg::OP_INVAL ? oamt_pkg::RS_NOTFOUND :
                                         oamt_pkg::RS_REFUSED;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    state_reg <= S_OUT;
                    case (op_reg)
                        oamt_pkg::OP_CLEAR: begin
                            rs_reg   <= oamt_pkg::RS_CLEARED;
                            live_reg <= '0;
                            dead_reg <= '0;
                        end
                        oamt_pkg::OP_INVAL: if (rs_reg == oamt_pkg::RS_INVAL) begin
                            sw_reg   <= 1'b1;
                            wa_reg   <= idx_reg;
                            wd_reg   <= oamt_pkg::ST_TOMB;
                            live_reg <= live_reg - CW'(1);
                            dead_reg <= dead_reg + CW'(1);
                        end
                        oamt_pkg::OP_INSERT: if (rs_reg != oamt_pkg::RS_PRESENT) begin
                            if (live_reg >= limit_reg) begin
                                rs_reg <= oamt_pkg::RS_REFUSED;
                            end else if (tomb_v_reg) begin
                                rs_reg   <= oamt_pkg::RS_INSERTED;
                                sw_reg   <= 1'b1;
                                dw_reg   <= 1'b1;
                                wa_reg   <= tomb_reg;
                                wd_reg   <= oamt_pkg::ST_LIVE;
                                live_reg <= live_reg + CW'(1);
                                dead_reg <= dead_reg - CW'(1);
                            end else if (empty_v_reg && used1 <= (CW+1)'(LOAD_MAX)) begin
                                rs_reg   <= oamt_pkg::RS_INSERTED;
                                sw_reg   <= 1'b1;
                                dw_reg   <= 1'b1;
                                wa_reg   <= empty_reg;
                                wd_reg   <= oamt_pkg::ST_LIVE;
                                live_reg <= live_reg + CW'(1);
                            end else begin
                                rs_reg <= oamt_pkg::RS_REFUSED;
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    // The earlier result has left by now or leaves this cycle.
                    if (!ov_reg || m_tready) begin
                        ov_reg    <= 1'b1;
                        m_tuser   <= rs_reg;
                        m_tdata   <= {1'b0, dead_reg, live_reg,
                                      {(48-HANDLE_BITS){1'b0}}, fp_reg, fv_reg} ;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
endmodule
`default_nettype wire

// File: rtl/oamt_checker.sv
// Port checker for the memo table, bound to the top level.
`default_nettype none
module oamt_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [79:0]  m_tdata,
    input wire [2:0]   m_tuser
);
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    // Cleared reports zero counts.
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == oamt_pkg::RS_CLEARED |-> m_tdata[78:51] == 28'd0)
        else $error("clear with nonzero counts");
    // Non-hit results carry no handle.
    a_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != oamt_pkg::RS_HIT |-> m_tdata[50:0] == 51'd0)
        else $error("handle on non-hit");
    // Accepting an item drops s_tready, so no two items are accepted back to back.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");
endmodule

bind open_addressing_memo_table_top oamt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));
`default_nettype wire
